/* rtl/indexed_sequence_store_assert.svh */
// Assertion macros shared by the indexed sequence store modules.
// Depends on nothing; defining SYNTH turns every macro into an empty body.
`ifndef INDEXED_SEQUENCE_STORE_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_ASSERT_SVH

`ifndef SYNTH
// The expression holds at every clock edge outside reset.
`define ISS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("indexed_sequence_store: invariant violated");
// When the antecedent holds, the consequent holds in the same cycle.
`define ISS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed_sequence_store: implication violated");
// When the antecedent holds, the consequent holds in the next cycle.
`define ISS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed_sequence_store: next-cycle check violated");
`else
`define ISS_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ISS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ISS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/iss_pkg.sv */
// Package for the indexed sequence store: field widths, operation and
// status codes, and the command and status types between controller and datapath.
package iss_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int MODE_W = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    localparam logic [MODE_W-1:0] MODE_READ = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HEAD = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TAIL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_AT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL  = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Controller to datapath.
    typedef struct packed {
        logic capture;   // latch the request payload
        logic execute;   // apply the operation and load the result register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;  // result register is empty or drains this cycle
    } t_sts;

endpackage

/* rtl/iss_req_if.sv */
// Request channel of the indexed sequence store: valid/ready plus payload.
// Depends on iss_pkg for the field widths.
interface iss_req_if;
    logic                              valid;
    logic                              ready;
    logic [iss_pkg::MODE_W-1:0]        mode;
    logic [iss_pkg::POS_W-1:0]         position;
    logic signed [iss_pkg::DATA_W-1:0] value;

    modport source (output valid, output mode, output position, output value,
                    input ready);
    modport sink   (input valid, input mode, input position, input value,
                    output ready);
endinterface

/* rtl/iss_rsp_if.sv */
// Response channel of the indexed sequence store: valid/ready plus payload.
// Depends on iss_pkg for the field widths.
interface iss_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [iss_pkg::DATA_W-1:0] read_value;
    logic                              found;
    logic [iss_pkg::STAT_W-1:0]        status;
    logic [iss_pkg::CNT_W-1:0]         count;

    modport source (output valid, output read_value, output found, output status,
                    output count, input ready);
    modport sink   (input valid, input read_value, input found, input status,
                    input count, output ready);
endinterface

/* rtl/iss_ctrl.sv */
// Controller of the indexed sequence store: two-state sequencer that takes
// a request, then executes it once the result register is free. Uses iss_pkg.
`include "indexed_sequence_store_assert.svh"

module iss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  iss_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output iss_pkg::t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_in_ready      = (r_state == S_IDLE);
        o_cmd.capture   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.execute   = (r_state == S_EXEC) && i_sts.out_free;
        n_state         = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ISS_ASSERT_IMPLIES(a_no_cap_and_exec, i_clk, i_rst_n, o_cmd.capture, !o_cmd.execute)
    `ISS_ASSERT_NEXT(a_cap_then_exec_state, i_clk, i_rst_n, o_cmd.capture, r_state == S_EXEC)
    `ISS_ASSERT_NEXT(a_exec_then_idle, i_clk, i_rst_n, o_cmd.execute, o_in_ready)

endmodule

/* rtl/iss_dp.sv */
// Datapath of the indexed sequence store: request register, a chain of
// shifting element cells, the length counter and the result register. Uses iss_pkg.
`include "indexed_sequence_store_assert.svh"

module iss_dp #(
    parameter int DEPTH = iss_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  iss_pkg::t_cmd                     i_cmd,
    output iss_pkg::t_sts                     o_sts,
    input  logic [iss_pkg::MODE_W-1:0]        i_mode,
    input  logic [iss_pkg::POS_W-1:0]         i_position,
    input  logic signed [iss_pkg::DATA_W-1:0] i_value,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic signed [iss_pkg::DATA_W-1:0] o_read_value,
    output logic                              o_found,
    output logic [iss_pkg::STAT_W-1:0]        o_status,
    output logic [iss_pkg::CNT_W-1:0]         o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    // Common compare width for lengths, positions and cell indexes.
    localparam int W  = (LW > iss_pkg::POS_W) ? LW : iss_pkg::POS_W;
    localparam int CW = (W > iss_pkg::CNT_W) ? W : iss_pkg::CNT_W;

    localparam logic [LW-1:0] FULL_LEN = LW'(DEPTH);
    localparam logic [LW-1:0] ONE_LEN  = LW'(1);

    logic [iss_pkg::MODE_W-1:0]        r_mode;
    logic [iss_pkg::POS_W-1:0]         r_pos;
    logic signed [iss_pkg::DATA_W-1:0] r_val;
    logic signed [iss_pkg::DATA_W-1:0] r_cell [DEPTH];
    logic [LW-1:0]                     r_len;
    logic [LW-1:0]                     n_len;

    logic                              r_out_vld;
    logic signed [iss_pkg::DATA_W-1:0] r_out_rd;
    logic                              r_out_hit;
    logic [iss_pkg::STAT_W-1:0]        r_out_st;

    logic [W-1:0]                      w_len;
    logic [W-1:0]                      w_pos;
    logic [W-1:0]                      w_ins_pos;
    logic                              w_full;
    logic                              w_do_ins;
    logic                              w_do_del;
    logic                              w_hit;
    logic signed [iss_pkg::DATA_W-1:0] w_rd;
    logic [iss_pkg::STAT_W-1:0]        w_st;
    logic [CW-1:0]                     w_cnt;

    // Request register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_pos  <= i_position;
            r_val  <= i_value;
        end
    end

    // Operation decode.
    always_comb begin
        w_len     = W'(r_len);
        w_pos     = W'(r_pos);
        w_full    = (r_len == FULL_LEN);
        w_ins_pos = '0;
        w_do_ins  = 1'b0;
        w_do_del  = 1'b0;
        w_hit     = 1'b0;
        w_rd      = '0;
        w_st      = iss_pkg::ST_DONE;
        unique case (r_mode)
            iss_pkg::MODE_READ: begin
                if (w_pos < w_len) begin
                    w_hit = 1'b1;
                    w_rd  = r_cell[w_pos[AW-1:0]];
                end else begin
                    w_st = iss_pkg::ST_RANGE;
                end
            end
            iss_pkg::MODE_HEAD: begin
                w_ins_pos = '0;
                if (w_full) begin
                    w_st = iss_pkg::ST_FULL;
                end else begin
                    w_do_ins = 1'b1;
                end
            end
            iss_pkg::MODE_TAIL: begin
                w_ins_pos = w_len;
                if (w_full) begin
                    w_st = iss_pkg::ST_FULL;
                end else begin
                    w_do_ins = 1'b1;
                end
            end
            iss_pkg::MODE_AT: begin
                w_ins_pos = w_pos;
                // The range check comes before the full check.
                if (w_pos > w_len) begin
                    w_st = iss_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_st = iss_pkg::ST_FULL;
                end else begin
                    w_do_ins = 1'b1;
                end
            end
            iss_pkg::MODE_DEL: begin
                if (w_pos < w_len) begin
                    w_do_del = 1'b1;
                end else begin
                    w_st = iss_pkg::ST_RANGE;
                end
            end
            default: w_st = iss_pkg::ST_RANGE;
        endcase

        n_len = r_len;
        if (w_do_ins) begin
            n_len = r_len + ONE_LEN;
        end else if (w_do_del) begin
            n_len = r_len - ONE_LEN;
        end
    end

    // Shifting cells take their lower neighbor on insert, upper neighbor on delete.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        localparam logic [W-1:0] IDX = W'(gi);
        logic signed [iss_pkg::DATA_W-1:0] w_up;
        logic signed [iss_pkg::DATA_W-1:0] w_dn;

        if (gi > 0) begin : g_lo
            assign w_dn = r_cell[gi-1];
        end else begin : g_lo0
            assign w_dn = r_cell[gi];
        end
        if (gi < DEPTH - 1) begin : g_hi
            assign w_up = r_cell[gi+1];
        end else begin : g_hi0
            assign w_up = r_cell[gi];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.execute) begin
                if (w_do_ins && (IDX == w_ins_pos)) begin
                    r_cell[gi] <= r_val;
                end else if (w_do_ins && (IDX > w_ins_pos)) begin
                    r_cell[gi] <= w_dn;
                end else if (w_do_del && (IDX >= w_pos)) begin
                    r_cell[gi] <= w_up;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.execute) begin
                r_len     <= n_len;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_out_rd  <= w_rd;
            r_out_hit <= w_hit;
            r_out_st  <= w_st;
        end
    end

    assign w_cnt          = CW'(r_len);
    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_read_value   = r_out_rd;
    assign o_found        = r_out_hit;
    assign o_status       = r_out_st;
    assign o_count        = w_cnt[iss_pkg::CNT_W-1:0];

    `ISS_ASSERT_ALWAYS(a_len_bounded, i_clk, i_rst_n, r_len <= FULL_LEN)
    `ISS_ASSERT_NEXT(a_len_only_on_exec, i_clk, i_rst_n, !i_cmd.execute, $stable(r_len))
    `ISS_ASSERT_IMPLIES(a_exec_needs_room, i_clk, i_rst_n, i_cmd.execute, o_sts.out_free)
    `ISS_ASSERT_IMPLIES(a_single_edit, i_clk, i_rst_n, w_do_ins, !w_do_del)

endmodule

/* rtl/indexed_sequence_store.sv */
// Indexed sequence store, top level.
// Request channel i_req carries mode, position and value; response channel
// o_rsp returns read_value, found, status and count, one response per request.
// Both channels use valid/ready; a transfer happens when both are high.
// Modes: read, insert at head, insert at tail, insert at index, delete.
// Timing: a request is taken in the idle state and executed in the execute
// state once the result register is free, so the response is valid on the
// cycle after the execute step; a new request is accepted only after the last
// one has executed. The two-state sequencer in the controller sets this pace;
// every cell of the element chain shifts together in the execute step.
// The response register frees the request side: the next request is taken
// while a response still waits. If the receiver holds ready low, the next
// request waits in its execute step until the response register drains.
// Reset (synchronous, active low) empties the store and drops any pending
// response; element cells are not cleared, since only indexes below the length are ever read.
// Depends on iss_pkg, iss_req_if, iss_rsp_if, iss_ctrl and iss_dp.
module indexed_sequence_store #(
    parameter int DEPTH = iss_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iss_req_if.sink   i_req,
    iss_rsp_if.source o_rsp
);

    iss_pkg::t_cmd w_cmd;
    iss_pkg::t_sts w_sts;
    logic          w_in_ready;

    iss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    iss_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_mode       (i_req.mode),
        .i_position   (i_req.position),
        .i_value      (i_req.value),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_read_value (o_rsp.read_value),
        .o_found      (o_rsp.found),
        .o_status     (o_rsp.status),
        .o_count      (o_rsp.count)
    );

    assign i_req.ready = w_in_ready;

endmodule

/* verif/tb_indexed_sequence_store.sv */
// Testbench for indexed_sequence_store: random and directed operations with a
// scoreboard that mirrors the stored sequence and checks every response in order.
// Depends on iss_pkg, iss_req_if, iss_rsp_if and the indexed_sequence_store RTL.
module tb_indexed_sequence_store;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MODE_W = iss_pkg::MODE_W;
    localparam int POS_W  = iss_pkg::POS_W;
    localparam int DATA_W = iss_pkg::DATA_W;
    localparam int STAT_W = iss_pkg::STAT_W;
    localparam int CNT_W  = iss_pkg::CNT_W;

    localparam int STORE_DEPTH = iss_pkg::DEPTH_DEF;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 200;
    localparam int MAX_REPORTS = 10;

    // Encodings above delete are not operations; the block must ignore them.
    localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;
    localparam logic [POS_W-1:0] POS_TOP = '1;

    localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] DATA_ONES = -32'sd1;

    typedef struct {
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         count;
    } t_store_rsp;

    class t_seq_store_scoreboard;
        logic signed [DATA_W-1:0] elems [STORE_DEPTH];
        int unsigned              len;
        t_store_rsp               expected_rsp [$];
        int                       errors;

        function new();
            len = 0;
            errors = 0;
        endfunction

        // Range is checked before fullness, as the block does.
        function logic [STAT_W-1:0] insert_value(int unsigned at,
                                                 logic signed [DATA_W-1:0] val);
            if (at > len)
                return iss_pkg::ST_RANGE;
            if (len >= STORE_DEPTH)
                return iss_pkg::ST_FULL;
            for (int i = int'(len); i > int'(at); i--)
                elems[i] = elems[i-1];
            elems[at] = val;
            len++;
            return iss_pkg::ST_DONE;
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                                   logic signed [DATA_W-1:0] val);
            t_store_rsp rsp;
            rsp.read_value = '0;
            rsp.found = 1'b0;
            rsp.status = iss_pkg::ST_DONE;
            case (mode)
                iss_pkg::MODE_READ: begin
                    if (pos < len) begin
                        rsp.read_value = elems[pos];
                        rsp.found = 1'b1;
                    end else begin
                        rsp.status = iss_pkg::ST_RANGE;
                    end
                end
                iss_pkg::MODE_HEAD: rsp.status = insert_value(0, val);
                iss_pkg::MODE_TAIL: rsp.status = insert_value(len, val);
                iss_pkg::MODE_AT:   rsp.status = insert_value(pos, val);
                iss_pkg::MODE_DEL: begin
                    if (pos < len) begin
                        for (int i = int'(pos); i < int'(len) - 1; i++)
                            elems[i] = elems[i+1];
                        len--;
                    end else begin
                        rsp.status = iss_pkg::ST_RANGE;
                    end
                end
                default: rsp.status = iss_pkg::ST_RANGE;
            endcase
            rsp.count = CNT_W'(len);
            expected_rsp.push_back(rsp);
        endfunction

        function void check_response(t_store_rsp got);
            t_store_rsp want;
            if (expected_rsp.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("unexpected response: value=%0d found=%0b status=%0d count=%0d",
                             got.read_value, got.found, got.status, got.count);
                errors++;
                return;
            end
            want = expected_rsp.pop_front();
            if (got.read_value !== want.read_value || got.found !== want.found ||
                got.status !== want.status || got.count !== want.count) begin
                if (errors < MAX_REPORTS) begin
                    $display("response mismatch: expected value=%0d found=%0b status=%0d count=%0d",
                             want.read_value, want.found, want.status, want.count);
                    $display("                   got value=%0d found=%0b status=%0d count=%0d",
                             got.read_value, got.found, got.status, got.count);
                end
                errors++;
            end
        endfunction

        function void check_empty();
            if (expected_rsp.size() != 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0d responses never arrived", expected_rsp.size());
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    iss_req_if req_if ();
    iss_rsp_if rsp_if ();

    indexed_sequence_store DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_seq_store_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        int hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        t_store_rsp got;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            got.read_value = rsp_if.read_value;
            got.found = rsp_if.found;
            got.status = rsp_if.status;
            got.count = rsp_if.count;
            sb.check_response(got);
        end
    end

    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_indexed_sequence_store: FAIL");
            $finish;
        end
    end

    // Returns at the edge where the transfer happens, with valid still high.
    task automatic send_req(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                            input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode <= mode;
        req_if.position <= pos;
        req_if.value <= val;
        do @(posedge clk); while (!req_if.ready);
        sb.note_request(mode, pos, val);
        items_sent++;
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed operations around the current length; insert_pct
    // steers the store toward full or toward empty.
    task automatic send_random(input int insert_pct);
        logic [MODE_W-1:0]        mode;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        int unsigned              len;
        int                       pick;
        len = sb.len;
        pick = $urandom_range(99);
        if (pick < 3)
            mode = MODE_W'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST));
        else if (pick < 18)
            mode = iss_pkg::MODE_READ;
        else if ($urandom_range(99) < insert_pct) begin
            case ($urandom_range(2))
                0:       mode = iss_pkg::MODE_HEAD;
                1:       mode = iss_pkg::MODE_TAIL;
                default: mode = iss_pkg::MODE_AT;
            endcase
        end else begin
            mode = iss_pkg::MODE_DEL;
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            pos = POS_W'($urandom_range(POS_TOP, 0));
        end else if (pick < 25) begin
            case ($urandom_range(2))
                0:       pos = '0;
                1:       pos = POS_W'(len);
                default: pos = (len == 0) ? '0 : POS_W'(len - 1);
            endcase
        end else if (mode == iss_pkg::MODE_AT) begin
            pos = POS_W'($urandom_range(len, 0));
        end else begin
            pos = (len == 0) ? '0 : POS_W'($urandom_range(len - 1, 0));
        end
        if ($urandom_range(99) < 10) begin
            case ($urandom_range(3))
                0:       val = DATA_MIN;
                1:       val = DATA_MAX;
                2:       val = DATA_ONES;
                default: val = '0;
            endcase
        end else begin
            val = $urandom;
        end
        send_req(mode, pos, val);
    endtask

    task automatic run_phase(input int item_goal);
        int target;
        target = items_sent + item_goal;
        while (items_sent < target) begin
            case ($urandom_range(2))
                0: begin
                    while (sb.len < STORE_DEPTH && items_sent < target + 100)
                        send_random(90);
                    repeat (8) send_random(90);
                end
                1: begin
                    while (sb.len > 0 && items_sent < target + 100)
                        send_random(10);
                    repeat (8) send_random(10);
                end
                default: repeat (30) send_random(50);
            endcase
        end
    endtask

    initial begin
        int send_pcts [4];
        int stall_pcts [4];
        send_pcts = '{0, 48, 0, 19};
        stall_pcts = '{0, 0, 48, 19};
        sb = new();
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.mode <= iss_pkg::MODE_READ;
        req_if.position <= '0;
        req_if.value <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: misses on an empty store, inserts at both ends and in the
        // middle, deletes at the head and at the tail, ignored modes.
        send_req(iss_pkg::MODE_READ, '0, '0);
        send_req(iss_pkg::MODE_DEL, '0, '0);
        send_req(iss_pkg::MODE_AT, 7'd1, DATA_ONES);
        send_req(iss_pkg::MODE_AT, '0, DATA_MAX);
        send_req(iss_pkg::MODE_HEAD, '0, DATA_MIN);
        send_req(iss_pkg::MODE_TAIL, POS_TOP, DATA_ONES);
        send_req(iss_pkg::MODE_TAIL, '0, '0);
        send_req(iss_pkg::MODE_READ, '0, '0);
        send_req(iss_pkg::MODE_READ, POS_W'(sb.len - 1), '0);
        send_req(iss_pkg::MODE_READ, POS_W'(sb.len), '0);
        send_req(iss_pkg::MODE_AT, POS_W'(sb.len), 32'sh5555_5555);
        send_req(iss_pkg::MODE_AT, 7'd2, 32'shAAAA_AAAA);
        send_req(iss_pkg::MODE_DEL, '0, '0);
        send_req(iss_pkg::MODE_READ, '0, '0);
        send_req(iss_pkg::MODE_READ, 7'd1, '0);
        send_req(iss_pkg::MODE_DEL, POS_W'(sb.len - 1), '0);
        send_req(iss_pkg::MODE_DEL, POS_TOP, '0);
        send_req(iss_pkg::MODE_READ, POS_TOP, '0);
        send_req(iss_pkg::MODE_AT, POS_TOP, DATA_MAX);
        for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
            send_req(MODE_W'(m), POS_TOP, DATA_ONES);
        send_req(iss_pkg::MODE_READ, 7'd64, '0);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_pcts[p];
            stall_pct = stall_pcts[p];
            // The first phase starts with a long receiver hold-off so that the
            // block fills up and pushes back on the request side.
            if (p == 0)
                hold_request = HOLD_CYCLES;
            run_phase(PHASE_ITEMS);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_empty();
        if (sb.errors == 0)
            $display("tb_indexed_sequence_store: PASS");
        else
            $display("tb_indexed_sequence_store: FAIL");
        $finish;
    end

endmodule
